/* hw/rtl/tsca_pkg.sv */
// Shared types, codes and constants for the timed slot cache allocator.
// Used by every module of the block; depends on nothing.
package tsca_pkg;

   localparam int ENTRIES_DEF = 256;
   localparam int IN_W        = 104;
   localparam int OUT_W       = 24;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic [CSR_AW-1:0] ADDR_TIMEOUT = 3'd0;
   localparam logic [CSR_AW-1:0] ADDR_MAXNEW  = 3'd4;
   localparam logic [31:0]       TIMEOUT_RST  = 32'd5000;
   localparam logic [7:0]        MAXNEW_RST   = 8'd10;

   typedef enum logic [1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_BEGIN  = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      OUT_HIT     = 3'd0,
      OUT_REFRESH = 3'd1,
      OUT_INSERT  = 3'd2,
      OUT_LIMIT   = 3'd3,
      OUT_CTRL    = 3'd4
   } outcome_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SEARCH,
      S_MISS,
      S_SWEEP,
      S_SWEEP_END,
      S_POP_RD,
      S_POP,
      S_INSERT,
      S_REFRESH,
      S_DONE
   } state_type;

   typedef struct packed {
      logic        load;
      logic        clr_query;
      logic        restore;
      logic        scan_start;
      logic        scan_search;
      logic        scan_sweep;
      logic        miss;
      logic        sweep_end;
      logic        pop;
      logic        insert;
      logic        refresh;
      logic        finish;
      outcome_type outcome;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       search_done;
      logic       found;
      logic       hash_eq;
      logic       limit;
      logic       fc_zero;
      logic       sweep_done;
      logic       out_free;
   } sts_type;

endpackage

/* hw/rtl/tsca_csr.sv */
// Configuration registers of the slot cache allocator behind an APB-style port.
// Depends on tsca_pkg for addresses and reset values.
module tsca_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tsca_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [tsca_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [tsca_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output logic [31:0]                   timeout_ticks,
   output logic [7:0]                    max_new_per_query
);
   import tsca_pkg::*;

   logic [31:0] timeout_ff;
   logic [7:0]  maxnew_ff;
   logic        wr_en;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RST;
         maxnew_ff  <= MAXNEW_RST;
      end else if (wr_en) begin
         if (csr_paddr == ADDR_TIMEOUT) timeout_ff <= csr_pwdata;
         if (csr_paddr == ADDR_MAXNEW)  maxnew_ff  <= csr_pwdata[7:0];
      end
   end

   always_comb begin
      case (csr_paddr)
         ADDR_TIMEOUT: csr_prdata = timeout_ff;
         ADDR_MAXNEW:  csr_prdata = {24'd0, maxnew_ff};
         default:      csr_prdata = '0;
      endcase
   end

   assign timeout_ticks     = timeout_ff;
   assign max_new_per_query = maxnew_ff;
endmodule

/* hw/rtl/tsca_ctrl.sv */
// Sequencing state machine of the slot cache allocator.
// Depends on tsca_pkg; drives the datapath by command and reads its status.
module tsca_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  tsca_pkg::sts_type sts,
   output tsca_pkg::cmd_type cmd
);
   import tsca_pkg::*;

   state_type   state_ff, state_in;
   outcome_type outcome_ff, outcome_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         outcome_ff <= OUT_CTRL;
      end else begin
         state_ff   <= state_in;
         outcome_ff <= outcome_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      outcome_in = outcome_ff;
      case (state_ff)
         S_IDLE:
            if (req_tvalid) state_in = S_DECODE;
         S_DECODE: begin
            outcome_in = OUT_CTRL;
            if (sts.action == ACT_LOOKUP) state_in = S_SEARCH;
            else                          state_in = S_DONE;
         end
         S_SEARCH:
            if (sts.search_done) begin
               if (!sts.found) begin
                  state_in = S_MISS;
               end else if (sts.hash_eq) begin
                  outcome_in = OUT_HIT;
                  state_in   = S_DONE;
               end else begin
                  state_in = S_REFRESH;
               end
            end
         S_MISS:
            if (sts.limit) begin
               outcome_in = OUT_LIMIT;
               state_in   = S_DONE;
            end else if (sts.fc_zero) begin
               state_in = S_SWEEP;
            end else begin
               state_in = S_POP_RD;
            end
         S_SWEEP:
            if (sts.sweep_done) state_in = S_SWEEP_END;
         S_SWEEP_END: state_in = S_INSERT;
         S_POP_RD:    state_in = S_POP;
         S_POP:       state_in = S_INSERT;
         S_INSERT: begin
            outcome_in = OUT_INSERT;
            state_in   = S_DONE;
         end
         S_REFRESH: begin
            outcome_in = OUT_REFRESH;
            state_in   = S_DONE;
         end
         S_DONE:
            if (sts.out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.outcome = outcome_ff;
      req_tready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_DECODE: begin
            cmd.clr_query  = (sts.action == ACT_BEGIN);
            cmd.restore    = (sts.action == ACT_CLEAR);
            cmd.scan_start = (sts.action == ACT_LOOKUP);
         end
         S_SEARCH: cmd.scan_search = 1'b1;
         S_MISS: begin
            cmd.miss       = 1'b1;
            cmd.scan_start = !sts.limit && sts.fc_zero;
         end
         S_SWEEP:     cmd.scan_sweep = 1'b1;
         S_SWEEP_END: cmd.sweep_end  = 1'b1;
         S_POP:       cmd.pop        = 1'b1;
         S_INSERT:    cmd.insert     = 1'b1;
         S_REFRESH:   cmd.refresh    = 1'b1;
         S_DONE:      cmd.finish     = sts.out_free;
         default:     cmd            = '0;
      endcase
   end
endmodule

/* hw/rtl/tsca_dp.sv */
// Datapath of the slot cache allocator: slot memories, free stack, scan unit
// and result register. Depends on tsca_pkg; commanded by tsca_ctrl.
module tsca_dp #(
   parameter int ENTRIES = tsca_pkg::ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tsca_pkg::cmd_type          cmd,
   output tsca_pkg::sts_type          sts,
   input  logic [tsca_pkg::IN_W-1:0]  req_tdata,
   input  logic [31:0]                timeout_ticks,
   input  logic [7:0]                 max_new_per_query,
   input  logic                       rsp_tready,
   output logic                       rsp_tvalid,
   output logic [tsca_pkg::OUT_W-1:0] rsp_tdata
);
   import tsca_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] FULL = CW'(ENTRIES);

   // Item registers.
   action_type act_ff;
   logic [31:0] id_ff, hash_ff, now_ff;

   // Slot memories and free stack.
   logic [31:0]   key_mem   [ENTRIES];
   logic [31:0]   hash_mem  [ENTRIES];
   logic [31:0]   stamp_mem [ENTRIES];
   logic [IW-1:0] stack_mem [ENTRIES];
   logic [31:0]   key_rd_ff, hash_rd_ff, stamp_rd_ff;
   logic [IW-1:0] st_rd_ff;
   logic          sv_rd_ff;

   logic [ENTRIES-1:0] mapped_ff, sv_ff;
   logic [CW-1:0]      fc_ff, scan_idx_ff, freed_ff;
   logic [IW-1:0]      rd_idx_ff, hit_idx_ff, sel_ff, oldest_ff, last_ff;
   logic [IW-1:0]      rd_addr, wr_addr, top_addr;
   logic               rd_vld_ff, found_ff, hash_eq_ff, swept_ff;
   logic [30:0]        best_ff;
   logic [7:0]         nq_ff;

   logic        issue, hit_now, over, better, sweep_free, slot_we;
   logic [31:0] age;
   logic [8:0]  nq_next;

   logic        rsp_valid_ff;
   outcome_type res_out_ff;
   logic [7:0]  res_slot_ff;
   logic [8:0]  res_ev_ff;

   assign rd_addr  = scan_idx_ff[IW-1:0];
   assign top_addr = IW'(fc_ff - 1'b1);
   assign issue    = ((cmd.scan_search && !found_ff) || cmd.scan_sweep) && (scan_idx_ff != FULL);
   assign hit_now  = cmd.scan_search && rd_vld_ff && !found_ff && mapped_ff[rd_idx_ff] &&
                     (key_rd_ff == id_ff);
   assign age        = now_ff - stamp_rd_ff;
   assign over       = !age[31] && (age > timeout_ticks);
   assign better     = !age[31] && (age[30:0] > best_ff);
   assign sweep_free = cmd.scan_sweep && rd_vld_ff && over;
   assign nq_next    = {1'b0, nq_ff} + 9'd1;
   assign slot_we    = cmd.insert || cmd.refresh;
   assign wr_addr    = cmd.insert ? sel_ff : hit_idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= action_type'(req_tdata[1:0]);
         id_ff   <= req_tdata[33:2];
         hash_ff <= req_tdata[65:34];
         now_ff  <= req_tdata[97:66];
      end
   end

   always_ff @(posedge clock) begin
      key_rd_ff   <= key_mem[rd_addr];
      hash_rd_ff  <= hash_mem[rd_addr];
      stamp_rd_ff <= stamp_mem[rd_addr];
      if (slot_we) begin
         hash_mem[wr_addr]  <= hash_ff;
         stamp_mem[wr_addr] <= now_ff;
      end
      if (cmd.insert) key_mem[wr_addr] <= id_ff;
   end

   // The free stack reads its top every cycle; an entry never pushed reads as its own index.
   always_ff @(posedge clock) begin
      st_rd_ff <= stack_mem[top_addr];
      sv_rd_ff <= sv_ff[top_addr];
      if (sweep_free) stack_mem[IW'(fc_ff)] <= rd_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff     <= '0;
         mapped_ff <= '0;
         fc_ff     <= FULL;
         nq_ff     <= '0;
      end else begin
         if (cmd.restore) begin
            sv_ff     <= '0;
            mapped_ff <= '0;
            fc_ff     <= FULL;
         end else if (sweep_free) begin
            sv_ff[IW'(fc_ff)]    <= 1'b1;
            mapped_ff[rd_idx_ff] <= 1'b0;
            fc_ff                <= fc_ff + 1'b1;
         end else if (cmd.sweep_end) begin
            if (fc_ff != '0) fc_ff <= fc_ff - 1'b1;
         end else if (cmd.pop) begin
            fc_ff <= fc_ff - 1'b1;
         end else if (cmd.insert) begin
            mapped_ff[sel_ff] <= 1'b1;
         end
         if (cmd.clr_query) nq_ff <= '0;
         else if (cmd.miss && nq_ff != 8'hFF) nq_ff <= nq_ff + 1'b1;
      end
   end

   // Scan unit shared by the key search and the eviction sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
         swept_ff  <= 1'b0;
      end else begin
         if (cmd.load) swept_ff <= 1'b0;
         if (cmd.scan_start) begin
            scan_idx_ff <= '0;
            rd_vld_ff   <= 1'b0;
            found_ff    <= 1'b0;
            best_ff     <= '0;
            oldest_ff   <= '0;
            freed_ff    <= '0;
            swept_ff    <= cmd.miss;
         end else begin
            rd_vld_ff <= issue;
            if (issue) scan_idx_ff <= scan_idx_ff + 1'b1;
            rd_idx_ff <= rd_addr;
            if (hit_now) begin
               found_ff   <= 1'b1;
               hit_idx_ff <= rd_idx_ff;
               hash_eq_ff <= (hash_rd_ff == hash_ff);
            end
            if (sweep_free) begin
               freed_ff <= freed_ff + 1'b1;
               last_ff  <= rd_idx_ff;
            end else if (cmd.scan_sweep && rd_vld_ff && better) begin
               best_ff   <= age[30:0];
               oldest_ff <= rd_idx_ff;
            end
            // With nothing timed out, the oldest slot is counted as freed and taken at once, bypassing the free stack.
            if (cmd.sweep_end) begin
               if (fc_ff == '0) begin
                  sel_ff   <= oldest_ff;
                  freed_ff <= CW'(1);
               end else begin
                  sel_ff <= last_ff;
               end
            end
            if (cmd.pop) sel_ff <= sv_rd_ff ? st_rd_ff : top_addr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
         res_out_ff   <= cmd.outcome;
         case (cmd.outcome)
            OUT_HIT, OUT_REFRESH: res_slot_ff <= 8'(hit_idx_ff);
            OUT_INSERT:           res_slot_ff <= 8'(sel_ff);
            default:              res_slot_ff <= '0;
         endcase
         res_ev_ff <= (cmd.outcome == OUT_INSERT && swept_ff) ? 9'(freed_ff) : 9'd0;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, res_ev_ff, res_slot_ff, res_out_ff};

   assign sts.action      = act_ff;
   assign sts.search_done = found_ff || (scan_idx_ff == FULL && !rd_vld_ff);
   assign sts.found       = found_ff;
   assign sts.hash_eq     = hash_eq_ff;
   assign sts.limit       = nq_next > {1'b0, max_new_per_query};
   assign sts.fc_zero     = (fc_ff == '0);
   assign sts.sweep_done  = (scan_idx_ff == FULL) && !rd_vld_ff;
   assign sts.out_free    = !rsp_valid_ff || rsp_tready;
endmodule

/* hw/rtl/timed_slot_cache_allocator.sv */
// Top level of the timed slot cache allocator: registers, controller, datapath.
// Depends on tsca_pkg, tsca_csr, tsca_ctrl and tsca_dp.
//
//   port group | direction | contents
//   req_*      | in        | one lookup, begin-query or clear item
//   rsp_*      | out       | one result item for each request item
//   csr_*      | in/out    | timeout and per-query insertion limit
//
// Items are handled one at a time. A control item needs no scan; a lookup scans
// the key memory one slot a cycle, over up to ENTRIES slots for a hit and all of
// them for a miss, and an insert with an empty free stack adds a sweep over all
// slots of the timestamp memory. Reset is synchronous and needs no clearing pass.
// A stalled result sits in the output register while the next item is accepted.
module timed_slot_cache_allocator #(
   parameter int ENTRIES = tsca_pkg::ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // action[1:0], entity_id[33:2], position_hash[65:34], now_ticks[97:66]
   input  logic [tsca_pkg::IN_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // outcome[2:0], slot[10:3], evicted_count[19:11]
   output logic [tsca_pkg::OUT_W-1:0]    rsp_tdata,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tsca_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [tsca_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [tsca_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import tsca_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [31:0] timeout_ticks;
   logic [7:0]  max_new_per_query;

   tsca_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .timeout_ticks, .max_new_per_query
   );

   tsca_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .sts, .cmd
   );

   tsca_dp #(.ENTRIES(ENTRIES)) u_dp (
      .clock, .reset, .cmd, .sts, .req_tdata, .timeout_ticks,
      .max_new_per_query, .rsp_tready, .rsp_tvalid, .rsp_tdata
   );
endmodule

/* hw/rtl/tsca_checker.sv */
// Port-level checks on the timed slot cache allocator, bound to its top level.
// Depends on tsca_pkg for the outcome codes.
module tsca_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [tsca_pkg::OUT_W-1:0]    rsp_tdata
);
   import tsca_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted while one is in work");

   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= OUT_CTRL)
      else $error("outcome code out of range");

   a_refused_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == OUT_LIMIT || rsp_tdata[2:0] == OUT_CTRL)
      |-> rsp_tdata[19:3] == '0)
      else $error("refused or control item carries slot or eviction count");

   a_evict_only_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[19:11] != '0 |-> rsp_tdata[2:0] == OUT_INSERT)
      else $error("eviction count on an item that did not insert");
endmodule

bind timed_slot_cache_allocator tsca_checker u_tsca_checker (.*);
